// File: hw/rtl/qots_pkg.sv
// qots_pkg: constants, types and box overlap functions for the overlap search table.
// No dependencies; used by quad_overlap_table_search.

package qots_pkg;

  localparam int SLOTS       = 32;
  localparam int COORD_BITS  = 16;
  localparam int TABLE_CAP   = 32;
  localparam int TABLE_LIMIT = (SLOTS < TABLE_CAP) ? SLOTS : TABLE_CAP;

  localparam int SLOT_W      = 5;
  localparam int CNT_W       = 6;
  localparam int COORD_W     = 16;
  localparam int LANES       = 4;
  localparam int QUAD_W      = LANES * COORD_W;
  localparam int IN_DATA_W   = 136;
  localparam int OUT_DATA_W  = 16;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [LANES-1:0] quad_t;

  function automatic coord_t sext_coord(logic [COORD_W-1:0] v);
    logic signed [COORD_BITS-1:0] t;
    t = v[COORD_BITS-1:0];
    return COORD_W'(t);
  endfunction

  function automatic logic inside_box(coord_t px, coord_t py, coord_t ax, coord_t ay,
                                      coord_t cx, coord_t cy);
    coord_t xl;
    coord_t xh;
    coord_t yl;
    coord_t yh;
    xl = (ax < cx) ? ax : cx;
    xh = (ax < cx) ? cx : ax;
    yl = (ay < cy) ? ay : cy;
    yh = (ay < cy) ? cy : ay;
    return (px >= xl) && (px <= xh) && (py >= yl) && (py <= yh);
  endfunction

  function automatic logic boxes_overlap(quad_t sx, quad_t sy, quad_t qx, quad_t qy);
    logic r;
    r = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      r = r | inside_box(sx[i], sy[i], qx[0], qy[0], qx[2], qy[2]);
      r = r | inside_box(qx[i], qy[i], sx[0], sy[0], sx[2], sy[2]);
    end
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        r = r | ((sx[i] == qx[j]) && (sy[i] == qy[j]));
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/qots_ram.sv
// qots_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.

module qots_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/quad_overlap_table_search.sv
// quad_overlap_table_search: table of four-corner boxes with an overlap search.
// Depends on qots_pkg and qots_ram (x and y coordinate stores).
//
//  channel  dir  tdata                                   tuser  tlast
//  s_axis   in   slot, corner_a_x .. corner_d_y          func   -
//  m_axis   out  hit_slot, match_count                   hit    last
//
// A load writes its slot when accepted. A query steps through accept, one RAM read
// per slot, one compare and one closing result.
// The scan rate is set by the single read port of the coordinate RAMs.
// Reset clears the valid bits, the scan control and the output valid.
// A stalled output holds the scan, the RAM read data and the compare stage.

module quad_overlap_table_search
  import qots_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[4:0], a_x[20:5], a_y[36:21], b_x[52:37], b_y[68:53],
  // c_x[84:69], c_y[100:85], d_x[116:101], d_y[132:117], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit_slot[4:0], match_count[10:5], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // hit
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   rd_cnt;
  logic               cmp_valid;
  logic [SLOT_W-1:0]  cmp_idx;
  logic [TABLE_CAP-1:0] slot_valid;
  quad_t              qx;
  quad_t              qy;
  logic [CNT_W-1:0]   count;
  logic [SLOT_W-1:0]  out_slot;
  logic [CNT_W-1:0]   out_count;

  logic               in_xfer;
  logic               advance;
  logic               issue;
  logic               cmp_hit;
  logic               close_now;
  logic               load_ok;
  logic [SLOT_W-1:0]  in_slot;
  quad_t              in_x;
  quad_t              in_y;
  logic [QUAD_W-1:0]  rd_x;
  logic [QUAD_W-1:0]  rd_y;

  always_comb begin
    in_slot = s_axis_tdata[SLOT_W-1:0];
    for (int k = 0; k < LANES; k++) begin
      in_x[k] = sext_coord(s_axis_tdata[SLOT_W + 2*k*COORD_W +: COORD_W]);
      in_y[k] = sext_coord(s_axis_tdata[SLOT_W + (2*k+1)*COORD_W +: COORD_W]);
    end
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    in_xfer       = s_axis_tvalid && s_axis_tready;
    load_ok       = in_xfer && (s_axis_tuser == FUNC_LOAD) &&
                    ({1'b0, in_slot} < CNT_W'(TABLE_LIMIT));
    advance       = !m_axis_tvalid || m_axis_tready;
    issue         = (state == ST_SCAN) && advance && (rd_cnt < CNT_W'(TABLE_LIMIT));
    cmp_hit       = cmp_valid && slot_valid[cmp_idx] &&
                    boxes_overlap(quad_t'(rd_x), quad_t'(rd_y), qx, qy);
    close_now     = (state == ST_SCAN) && advance && !cmp_valid &&
                    (rd_cnt == CNT_W'(TABLE_LIMIT));
    state_next    = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser == FUNC_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (close_now) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  qots_ram #(.WIDTH(QUAD_W), .DEPTH(TABLE_CAP)) x_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (in_slot),
    .wdata (QUAD_W'(in_x)),
    .re    (issue),
    .raddr (rd_cnt[SLOT_W-1:0]),
    .rdata (rd_x)
  );

  qots_ram #(.WIDTH(QUAD_W), .DEPTH(TABLE_CAP)) y_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (in_slot),
    .wdata (QUAD_W'(in_y)),
    .re    (issue),
    .raddr (rd_cnt[SLOT_W-1:0]),
    .rdata (rd_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      cmp_valid  <= 1'b0;
      rd_cnt     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_ok) begin
        slot_valid[in_slot] <= 1'b1;
      end
      if (in_xfer && (s_axis_tuser == FUNC_QUERY)) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= CNT_W'(rd_cnt + 1'b1);
      end
      if ((state == ST_SCAN) && advance) begin
        cmp_valid <= issue;
      end
      if (advance) begin
        m_axis_tvalid <= cmp_hit || close_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (s_axis_tuser == FUNC_QUERY)) begin
      qx    <= in_x;
      qy    <= in_y;
      count <= '0;
    end else if (advance && cmp_hit) begin
      count <= CNT_W'(count + 1'b1);
    end
    if (issue) begin
      cmp_idx <= rd_cnt[SLOT_W-1:0];
    end
    if (advance && cmp_hit) begin
      m_axis_tuser <= 1'b1;
      out_slot     <= cmp_idx;
      out_count    <= CNT_W'(count + 1'b1);
      m_axis_tlast <= 1'b0;
    end else if (close_now) begin
      m_axis_tuser <= 1'b0;
      out_slot     <= '0;
      out_count    <= count;
      m_axis_tlast <= 1'b1;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - SLOT_W - CNT_W)'(0), out_count, out_slot};

`ifndef NO_ASSERTIONS
  a_close_no_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser && (out_slot == '0)))
    else $error("closing result carries a slot");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (out_count != '0))
    else $error("hit result with zero match count");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == ST_SCAN))
    else $error("compare stage busy outside a scan");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (s_axis_tuser == FUNC_QUERY)) |=> ((state == ST_SCAN) && (rd_cnt == '0)))
    else $error("query transfer did not start a scan");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CNT_W'(TABLE_LIMIT))
    else $error("scan counter past table limit");
`endif

endmodule

// File: tb/sv/quad_overlap_table_search_tb.sv
// quad_overlap_table_search_tb: self-checking bench for the box overlap search table.
// Drives load and search transfers, predicts every result from its own box table.
// Depends on qots_pkg and quad_overlap_table_search.

module quad_overlap_table_search_tb;
  import qots_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_SETTLE     = 40;

  typedef struct packed {
    logic                          func;
    logic [SLOT_W-1:0]             slot;
    logic [LANES-1:0][COORD_W-1:0] xs;
    logic [LANES-1:0][COORD_W-1:0] ys;
  } box_op_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              last;
  } search_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  box_op_t        op_q[$];
  search_result_t search_results_q[$];
  box_op_t        op_in_flight;
  search_result_t seen_result;
  search_result_t want_result;

  int         table_x[TABLE_CAP][LANES];
  int         table_y[TABLE_CAP][LANES];
  bit [TABLE_CAP-1:0] table_valid = '0;

  int  errors = 0;
  int  loads_sent = 0;
  int  searches_sent = 0;
  int  hits_seen = 0;
  int  closings_seen = 0;
  int  cycle_cnt = 0;
  int  quiet_cycles = 0;
  bit  calm;

  quad_overlap_table_search DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  assign calm = (cycle_cnt[10:9] == 2'b11);

  function automatic bit corner_in_rect(int px, int py, int bx[LANES], int by[LANES]);
    int xl, xh, yl, yh;
    xl = (bx[0] < bx[2]) ? bx[0] : bx[2];
    xh = (bx[0] < bx[2]) ? bx[2] : bx[0];
    yl = (by[0] < by[2]) ? by[0] : by[2];
    yh = (by[0] < by[2]) ? by[2] : by[0];
    return (px >= xl) && (px <= xh) && (py >= yl) && (py <= yh);
  endfunction

  function automatic bit boxes_meet(int sx[LANES], int sy[LANES], int qx[LANES], int qy[LANES]);
    for (int i = 0; i < LANES; i++) begin
      if (corner_in_rect(sx[i], sy[i], qx, qy) || corner_in_rect(qx[i], qy[i], sx, sy))
        return 1'b1;
    end
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        if ((sx[i] == qx[j]) && (sy[i] == qy[j]))
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted transfer to the box table and queue the results it causes.
  function automatic void predict_table_op(box_op_t op);
    int qx[LANES], qy[LANES], sx[LANES], sy[LANES];
    int found;
    for (int k = 0; k < LANES; k++) begin
      qx[k] = $signed(op.xs[k]);
      qy[k] = $signed(op.ys[k]);
    end
    if (op.func == FUNC_LOAD) begin
      loads_sent++;
      if (op.slot < TABLE_LIMIT) begin
        table_x[op.slot] = qx;
        table_y[op.slot] = qy;
        table_valid[op.slot] = 1'b1;
      end
      return;
    end
    searches_sent++;
    found = 0;
    for (int s = 0; s < TABLE_LIMIT; s++) begin
      if (table_valid[s]) begin
        sx = table_x[s];
        sy = table_y[s];
        if (boxes_meet(sx, sy, qx, qy)) begin
          found++;
          search_results_q.push_back({1'b1, SLOT_W'(s), CNT_W'(found), 1'b0});
        end
      end
    end
    search_results_q.push_back({1'b0, SLOT_W'(0), CNT_W'(found), 1'b1});
  endfunction

  function automatic box_op_t quad_op(logic func, int slot, int ax, int ay, int bx, int by,
                                      int cx, int cy, int dx, int dy);
    box_op_t op;
    op.func  = func;
    op.slot  = SLOT_W'(slot);
    op.xs[0] = COORD_W'(ax);
    op.ys[0] = COORD_W'(ay);
    op.xs[1] = COORD_W'(bx);
    op.ys[1] = COORD_W'(by);
    op.xs[2] = COORD_W'(cx);
    op.ys[2] = COORD_W'(cy);
    op.xs[3] = COORD_W'(dx);
    op.ys[3] = COORD_W'(dy);
    return op;
  endfunction

  function automatic box_op_t rect_op(logic func, int slot, int ax, int ay, int cx, int cy);
    return quad_op(func, slot, ax, ay, ax, cy, cx, cy, cx, ay);
  endfunction

  // Mostly small boxes near the origin so searches hit; some fully random corners.
  function automatic box_op_t random_op(logic func, int slot);
    box_op_t op;
    logic [COORD_W-1:0] t;
    int cx, cy, w, h;
    if ($urandom_range(99) < 15) begin
      op.func = func;
      op.slot = SLOT_W'(slot);
      op.xs   = {$urandom, $urandom};
      op.ys   = {$urandom, $urandom};
      return op;
    end
    cx = int'($urandom_range(80)) - 40;
    cy = int'($urandom_range(80)) - 40;
    w  = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(20));
    h  = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(20));
    op = rect_op(func, slot, cx - w, cy - h, cx + w, cy + h);
    if ($urandom_range(3) == 0) begin
      t = op.xs[0]; op.xs[0] = op.xs[2]; op.xs[2] = t;
      t = op.ys[0]; op.ys[0] = op.ys[2]; op.ys[2] = t;
    end
    return op;
  endfunction

  task automatic drain();
    while (op_q.size() != 0 || s_axis_tvalid || search_results_q.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_table_op(op_in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          op_in_flight = op_q.pop_front();
          s_axis_tdata <= {3'b000, op_in_flight.ys[3], op_in_flight.xs[3],
                           op_in_flight.ys[2], op_in_flight.xs[2],
                           op_in_flight.ys[1], op_in_flight.xs[1],
                           op_in_flight.ys[0], op_in_flight.xs[0], op_in_flight.slot};
          s_axis_tuser  <= op_in_flight.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result = {m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                     m_axis_tdata[SLOT_W +: CNT_W], m_axis_tlast};
      if (search_results_q.size() == 0) begin
        $display("%0t: result with none expected, actual hit=%0d slot=%0d count=%0d last=%0d",
                 $time, seen_result.hit, seen_result.slot, seen_result.count,
                 seen_result.last);
        errors++;
      end else begin
        want_result = search_results_q.pop_front();
        if (seen_result !== want_result) begin
          $display("%0t: result mismatch, expected hit=%0d slot=%0d count=%0d last=%0d, actual hit=%0d slot=%0d count=%0d last=%0d",
                   $time, want_result.hit, want_result.slot, want_result.count,
                   want_result.last, seen_result.hit, seen_result.slot,
                   seen_result.count, seen_result.last);
          errors++;
        end else if (seen_result.last) begin
          closings_seen++;
        end else begin
          hits_seen++;
        end
      end
    end
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, then edge boxes
    op_q.push_back(random_op(FUNC_QUERY, $urandom_range(31)));
    op_q.push_back(rect_op(FUNC_LOAD, 0, 0, 0, 10, 10));
    op_q.push_back(rect_op(FUNC_LOAD, 31, -32768, -32768, 32767, 32767));
    op_q.push_back(rect_op(FUNC_LOAD, 5, 100, 100, 100, 100));
    op_q.push_back(quad_op(FUNC_LOAD, 7, 1000, 1000, 1050, 1050, 1010, 1010, 1060, 1060));
    op_q.push_back(rect_op(FUNC_LOAD, 9, -400, -400, -500, -500));
    op_q.push_back(rect_op(FUNC_LOAD, 12, 300, -100, 310, 100));
    op_q.push_back(rect_op(FUNC_QUERY, 3, 5, 5, 20, 20));
    op_q.push_back(quad_op(FUNC_QUERY, 17, 1100, 1100, 1050, 1050, 1110, 1110, 1200, 1200));
    op_q.push_back(rect_op(FUNC_QUERY, 30, 100, 100, 100, 100));
    op_q.push_back(rect_op(FUNC_QUERY, 0, -20000, 20000, -19990, 20010));
    op_q.push_back(rect_op(FUNC_LOAD, 31, 32767, 32767, 32760, 32760));
    op_q.push_back(rect_op(FUNC_QUERY, 31, -32768, -32768, -32760, -32760));
    op_q.push_back(rect_op(FUNC_QUERY, 21, 32767, 32767, -32768, -32768));
    op_q.push_back(rect_op(FUNC_QUERY, 8, 200, 0, 400, 10));
    op_q.push_back(rect_op(FUNC_QUERY, 14, 10, 5, 30, 30));
    op_q.push_back(rect_op(FUNC_QUERY, 2, -450, -450, -450, -450));
    drain();

    // full table, one search that hits every slot
    for (int s = 0; s < TABLE_CAP; s++)
      op_q.push_back(random_op(FUNC_LOAD, s));
    op_q.push_back(rect_op(FUNC_QUERY, $urandom_range(31), -32768, -32768, 32767, 32767));
    drain();

    for (int n = 0; n < 115; n++) begin
      if ($urandom_range(99) < 55)
        op_q.push_back(random_op(FUNC_LOAD, $urandom_range(31)));
      else
        op_q.push_back(random_op(FUNC_QUERY, $urandom_range(31)));
    end
    drain();
    repeat (END_SETTLE) @(posedge clk);

    if (search_results_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, search_results_q.size());
      errors++;
    end
    $display("covered %0d box loads and %0d searches (empty, full and overwritten table)",
             loads_sent, searches_sent);
    $display("checked %0d overlap hits and %0d closing counts, %0d errors",
             hits_seen, closings_seen, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/qots_pkg.sv
hw/rtl/qots_ram.sv
hw/rtl/quad_overlap_table_search.sv
tb/sv/quad_overlap_table_search_tb.sv
